/* rtl/first_fit_run_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit run allocator
// Shared forms of the concurrent checks, clocked on i_clk and held off while
// i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_RUN_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFRA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The condition must hold at every clock edge outside reset.
`define FFRA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond)) else $error(msg);

`endif

/* rtl/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit run allocator package
// Field widths, status and mode codes, and the default table size.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int SLOTS_DEF = 256;

    localparam int MODE_W   = 1;
    localparam int RUN_W    = 9;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int FIRST_W  = 8;
    localparam int END_W    = 9;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

endpackage

/* rtl/ffra_slot_ram.sv */
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffra_slot_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

/* rtl/first_fit_run_allocator_core.sv */
// ----------------------------------------------------------------------------
// First-fit run allocator core
// Allocates runs of contiguous slots first-fit and frees single slots.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table once, one slot per cycle, so it
// accepts no request until that sweep is done. Each slot's active bit and
// run length share one table word behind a single registered read port, and
// every request is walked through that port by a small sequencer. A free reads
// its slot and then frees it. An allocate hops run by run from the search
// start, then marks the granted run slot by slot; when the search fails on
// stale run lengths, a rebuild pass and a second search from slot 0 are
// added. Results stay on the output until taken, and the next request is
// accepted only after that.
`include "first_fit_run_allocator_core_assert.svh"

module first_fit_run_allocator_core #(
    parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ffra_pkg::MODE_W-1:0]   i_mode,
    input  logic [ffra_pkg::RUN_W-1:0]    i_run_length,
    input  logic [ffra_pkg::INDEX_W-1:0]  i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ffra_pkg::STATUS_W-1:0] o_status,
    output logic [ffra_pkg::FIRST_W-1:0]  o_first_slot,
    output logic [ffra_pkg::END_W-1:0]    o_end_mark
);

    import ffra_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = ((LEN_W > RUN_W) ? LEN_W : RUN_W) + 1;
    localparam int WORD_W = LEN_W + 1;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_FREE    = 8'b0000_0100,
        S_SEARCH  = 8'b0000_1000,
        S_REBUILD = 8'b0001_0000,
        S_RESTART = 8'b0010_0000,
        S_FILL    = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic [IDX_W-1:0]    r_e, n_e;
    logic [IDX_W-1:0]    r_s, n_s;
    logic [LEN_W-1:0]    r_k, n_k;
    logic [RUN_W-1:0]    r_n, n_n;
    logic [IDX_W-1:0]    r_search_start, n_search_start;
    logic                r_runs_fresh, n_runs_fresh;
    logic [LEN_W-1:0]    r_high_water, n_high_water;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]    r_first, n_first;
    logic                r_prev_act, n_prev_act;
    logic [LEN_W-1:0]    r_prev_run, n_prev_run;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    logic             rd_act;
    logic [LEN_W-1:0] rd_run;
    logic [CMP_W-1:0] hop_next;
    logic [CMP_W-1:0] grant_end;
    logic [LEN_W-1:0] rebuild_run;
    logic             idx_out_of_range;

    ffra_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_act = ram_rd_data[LEN_W];
    assign rd_run = ram_rd_data[LEN_W-1:0];

    // A zero run length would stall the walk, so it hops by one slot instead.
    assign hop_next = CMP_W'(r_e) + ((rd_run == '0) ? CMP_W'(1) : CMP_W'(rd_run));

    assign grant_end = CMP_W'(r_s) + CMP_W'(r_n);

    assign rebuild_run = ((r_ptr == IDX_W'(SLOTS - 1)) || (rd_act != r_prev_act))
                         ? LEN_W'(1) : LEN_W'(r_prev_run + LEN_W'(1));

    assign idx_out_of_range = (32'(i_slot_index) >= 32'(SLOTS));

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_status     = r_status;
    assign o_first_slot = FIRST_W'(r_first);
    assign o_end_mark   = END_W'(r_high_water);

    always_comb begin
        n_state        = r_state;
        n_ptr          = r_ptr;
        n_e            = r_e;
        n_s            = r_s;
        n_k            = r_k;
        n_n            = r_n;
        n_search_start = r_search_start;
        n_runs_fresh   = r_runs_fresh;
        n_high_water   = r_high_water;
        n_status       = r_status;
        n_first        = r_first;
        n_prev_act     = r_prev_act;
        n_prev_run     = r_prev_run;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = r_ptr;
        ram_wr_data    = '0;
        ram_rd_addr    = r_e;

        case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_ptr;
                ram_wr_data = {1'b0, LEN_W'(LEN_W'(SLOTS) - LEN_W'(r_ptr))};
                n_ptr       = IDX_W'(r_ptr + IDX_W'(1));
                if (r_ptr == IDX_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n     = i_run_length;
                    n_first = '0;
                    if (i_mode == MODE_FREE) begin
                        if (idx_out_of_range) begin
                            n_status = ST_BAD_FREE;
                            n_state  = S_OUT;
                        end else begin
                            ram_rd_addr = IDX_W'(i_slot_index);
                            n_e         = IDX_W'(i_slot_index);
                            n_state     = S_FREE;
                        end
                    end else if (i_run_length == '0) begin
                        n_status = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        ram_rd_addr = r_search_start;
                        n_e         = r_search_start;
                        n_state     = S_SEARCH;
                    end
                end
            end
            S_FREE: begin
                if (!rd_act) begin
                    n_status = ST_BAD_FREE;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_e;
                    ram_wr_data = {1'b0, LEN_W'(1)};
                    n_status    = ST_OK;
                end
                n_state = S_OUT;
            end
            S_SEARCH: begin
                if (!rd_act && (CMP_W'(rd_run) >= CMP_W'(r_n))) begin
                    n_s     = r_e;
                    n_k     = '0;
                    n_state = S_FILL;
                end else if (hop_next < CMP_W'(SLOTS)) begin
                    ram_rd_addr = IDX_W'(hop_next);
                    n_e         = IDX_W'(hop_next);
                end else if (!r_runs_fresh) begin
                    // Rebuild walks from the top slot down, one slot per cycle.
                    ram_rd_addr = IDX_W'(SLOTS - 1);
                    n_ptr       = IDX_W'(SLOTS - 1);
                    n_state     = S_REBUILD;
                end else begin
                    n_status = ST_FULL;
                    n_state  = S_OUT;
                end
            end
            S_REBUILD: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_ptr;
                ram_wr_data = {rd_act, rebuild_run};
                n_prev_act  = rd_act;
                n_prev_run  = rebuild_run;
                if (r_ptr == '0) begin
                    n_runs_fresh   = 1'b1;
                    n_search_start = '0;
                    n_state        = S_RESTART;
                end else begin
                    ram_rd_addr = IDX_W'(r_ptr - IDX_W'(1));
                    n_ptr       = IDX_W'(r_ptr - IDX_W'(1));
                end
            end
            S_RESTART: begin
                // Slot 0 was written last cycle, so its read is issued only now.
                ram_rd_addr = '0;
                n_e         = '0;
                n_state     = S_SEARCH;
            end
            S_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = IDX_W'(CMP_W'(r_s) + CMP_W'(r_k));
                ram_wr_data = {1'b1, LEN_W'(CMP_W'(r_n) - CMP_W'(r_k))};
                n_k         = LEN_W'(r_k + LEN_W'(1));
                if (CMP_W'(r_k) == CMP_W'(r_n) - CMP_W'(1)) begin
                    n_runs_fresh   = 1'b0;
                    n_search_start = r_s;
                    n_first        = r_s;
                    n_status       = ST_OK;
                    if (grant_end > CMP_W'(r_high_water)) begin
                        n_high_water = LEN_W'(grant_end);
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_ptr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_ptr          <= '0;
            r_search_start <= '0;
            r_runs_fresh   <= 1'b1;
            r_high_water   <= '0;
        end else begin
            r_state        <= n_state;
            r_ptr          <= n_ptr;
            r_search_start <= n_search_start;
            r_runs_fresh   <= n_runs_fresh;
            r_high_water   <= n_high_water;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e        <= n_e;
        r_s        <= n_s;
        r_k        <= n_k;
        r_n        <= n_n;
        r_status   <= n_status;
        r_first    <= n_first;
        r_prev_act <= n_prev_act;
        r_prev_run <= n_prev_run;
    end

    `FFRA_ASSERT_IMPLIES(a_fail_first_zero, o_out_valid && (o_status != ST_OK), o_first_slot == '0, "failed request reports a nonzero first slot")
    `FFRA_ASSERT_IMPLIES(a_fill_in_run, r_state == S_FILL, CMP_W'(r_k) < CMP_W'(r_n), "fill ran past the granted run")
    `FFRA_ASSERT_IMPLIES(a_grant_below_mark, o_out_valid && (o_status == ST_OK) && (r_runs_fresh == 1'b0) && (r_search_start == r_first), CMP_W'(r_first) < CMP_W'(r_high_water) || (r_n == '0), "granted run lies above the high-water mark")
    `FFRA_ASSERT_IMPLIES(a_mark_monotonic, ($past(r_state) != S_CLEAR) && (r_state != S_CLEAR), r_high_water >= $past(r_high_water), "high-water mark decreased")

endmodule
